@@ hw/rtl/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared widths and types for the circle push-out resolver.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int DIAM_BITS    = 16;
    localparam int RAD_BITS     = 16;
    localparam int SQ_BITS      = 2 * RAD_BITS;
    localparam int SUM_BITS     = SQ_BITS + 1;
    localparam int CMP_BITS     = 72;
    localparam int Q_BITS       = RAD_BITS;
    localparam int POS_BITS_DEF = 24;

    // search state for one axis: e = (2q-1)^2 s, f = (2q-1) s, c = (2ar)^2
    typedef struct packed {
        logic signed [CMP_BITS-1:0] e;
        logic signed [CMP_BITS-1:0] f;
        logic signed [CMP_BITS-1:0] c;
        logic [Q_BITS-1:0]          q;
    } t_axis;

    typedef struct packed {
        logic valid;
        logic overlap;
        logic zero;
        logic sx;
        logic sy;
    } t_front_ctl;

endpackage

@@ hw/rtl/cpr_front.sv @@
// ----------------------------------------------------------------------------
// cpr_front
// Three stages: offsets and radius, squares, distance test and targets.
// ----------------------------------------------------------------------------
module cpr_front import cpr_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [POS_BITS-1:0]        i_mx,
    input  logic [POS_BITS-1:0]        i_my,
    input  logic [DIAM_BITS-1:0]       i_md,
    input  logic [POS_BITS-1:0]        i_fx,
    input  logic [POS_BITS-1:0]        i_fy,
    input  logic [DIAM_BITS-1:0]       i_fd,
    output t_front_ctl                 o_ctl,
    output logic [RAD_BITS-1:0]        o_r,
    output logic [SUM_BITS-1:0]        o_s,
    output logic signed [CMP_BITS-1:0] o_cx,
    output logic signed [CMP_BITS-1:0] o_cy,
    output logic [POS_BITS-1:0]        o_mx,
    output logic [POS_BITS-1:0]        o_my,
    output logic [POS_BITS-1:0]        o_fx,
    output logic [POS_BITS-1:0]        o_fy
);

    localparam int DW = POS_BITS + 1;

    logic [2:0]          r_v;
    logic [DW-1:0]       r1_ax, r1_ay;
    logic                r1_sx, r1_sy;
    logic [RAD_BITS-1:0] r1_r, r2_r, r3_r;
    logic [POS_BITS-1:0] r1_mx, r1_my, r1_fx, r1_fy;
    logic [POS_BITS-1:0] r2_mx, r2_my, r2_fx, r2_fy;
    logic [POS_BITS-1:0] r3_mx, r3_my, r3_fx, r3_fy;
    logic                r2_near, r2_sx, r2_sy;
    logic [SQ_BITS-1:0]  r2_ax2, r2_ay2, r2_rr;
    logic                r3_ovl, r3_zero, r3_sx, r3_sy;
    logic [SUM_BITS-1:0] r3_s;
    logic signed [CMP_BITS-1:0] r3_cx, r3_cy;

    logic signed [DW-1:0]  n_dx, n_dy;
    logic [DIAM_BITS:0]    n_dsum;
    logic [SUM_BITS-1:0]   n_s;
    logic [2*SQ_BITS-1:0]  n_px, n_py;

    always_comb begin
        n_dx   = $signed({i_mx[POS_BITS-1], i_mx}) - $signed({i_fx[POS_BITS-1], i_fx});
        n_dy   = $signed({i_my[POS_BITS-1], i_my}) - $signed({i_fy[POS_BITS-1], i_fy});
        n_dsum = {1'b0, i_md} + {1'b0, i_fd};
        n_s    = {1'b0, r2_ax2} + {1'b0, r2_ay2};
        n_px   = r2_ax2 * r2_rr;
        n_py   = r2_ay2 * r2_rr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ax <= n_dx[DW-1] ? DW'(-n_dx) : DW'(n_dx);
        r1_ay <= n_dy[DW-1] ? DW'(-n_dy) : DW'(n_dy);
        r1_sx <= n_dx[DW-1];
        r1_sy <= n_dy[DW-1];
        r1_r  <= n_dsum[DIAM_BITS:1];
        r1_mx <= i_mx;
        r1_my <= i_my;
        r1_fx <= i_fx;
        r1_fy <= i_fy;

        r2_near <= (r1_ax < DW'(r1_r)) && (r1_ay < DW'(r1_r));
        r2_ax2  <= r1_ax[RAD_BITS-1:0] * r1_ax[RAD_BITS-1:0];
        r2_ay2  <= r1_ay[RAD_BITS-1:0] * r1_ay[RAD_BITS-1:0];
        r2_rr   <= r1_r * r1_r;
        r2_r    <= r1_r;
        r2_sx   <= r1_sx;
        r2_sy   <= r1_sy;
        r2_mx   <= r1_mx;
        r2_my   <= r1_my;
        r2_fx   <= r1_fx;
        r2_fy   <= r1_fy;

        r3_ovl  <= r2_near && (n_s < {1'b0, r2_rr});
        r3_zero <= (n_s == '0);
        r3_s    <= n_s;
        r3_cx   <= $signed({{(CMP_BITS-2*SQ_BITS-2){1'b0}}, n_px, 2'b00});
        r3_cy   <= $signed({{(CMP_BITS-2*SQ_BITS-2){1'b0}}, n_py, 2'b00});
        r3_r    <= r2_r;
        r3_sx   <= r2_sx;
        r3_sy   <= r2_sy;
        r3_mx   <= r2_mx;
        r3_my   <= r2_my;
        r3_fx   <= r2_fx;
        r3_fy   <= r2_fy;
    end

    assign o_ctl = '{valid: r_v[2], overlap: r3_ovl, zero: r3_zero, sx: r3_sx, sy: r3_sy};
    assign o_r   = r3_r;
    assign o_s   = r3_s;
    assign o_cx  = r3_cx;
    assign o_cy  = r3_cy;
    assign o_mx  = r3_mx;
    assign o_my  = r3_my;
    assign o_fx  = r3_fx;
    assign o_fy  = r3_fy;

endmodule

@@ hw/rtl/cpr_search_step.sv @@
// ----------------------------------------------------------------------------
// cpr_search_step
// One bit of the rounded push length, both axes, by shift-and-add squares.
// ----------------------------------------------------------------------------
module cpr_search_step import cpr_pkg::*; #(
    parameter int K = 0
) (
    input  logic                i_clk,
    input  logic [SUM_BITS-1:0] i_s,
    input  t_axis               i_ax,
    input  t_axis               i_ay,
    output logic [SUM_BITS-1:0] o_s,
    output t_axis               o_ax,
    output t_axis               o_ay
);

    function automatic t_axis step(t_axis a, logic [SUM_BITS-1:0] s);
        logic signed [CMP_BITS-1:0] sw;
        logic signed [CMP_BITS-1:0] cand;
        t_axis n;
        sw   = $signed({{(CMP_BITS-SUM_BITS){1'b0}}, s});
        cand = a.e + (a.f <<< (K + 2)) + (sw <<< (2 * K + 2));
        n    = a;
        if (cand <= a.c) begin
            n.e    = cand;
            n.f    = a.f + (sw <<< (K + 1));
            n.q[K] = 1'b1;
        end
        return n;
    endfunction

    t_axis               r_ax, r_ay;
    logic [SUM_BITS-1:0] r_s;

    always_ff @(posedge i_clk) begin
        r_ax <= step(i_ax, i_s);
        r_ay <= step(i_ay, i_s);
        r_s  <= i_s;
    end

    assign o_ax = r_ax;
    assign o_ay = r_ay;
    assign o_s  = r_s;

endmodule

@@ hw/rtl/circle_pushout_resolve.sv @@
// ----------------------------------------------------------------------------
// circle_pushout_resolve
// Moves a circle out of a fixed circle onto the contact distance.
// ----------------------------------------------------------------------------
//  channel | handshake          | fields
//  in      | start, busy        | i_mover_x/y, i_mover_diameter, i_fixed_x/y,
//          |                    | i_fixed_diameter
//  out     | o_strobe           | o_resolved_x, o_resolved_y, o_pushed
//
//  One pair per cycle; 3 front stages, 16 search stages and one output stage.
//  The search resolves one bit of the push length per stage.
//  busy is always low. Synchronous reset clears the valid pipe only.
//  The receiver cannot stall; each result strobes for one cycle.
// ----------------------------------------------------------------------------
module circle_pushout_resolve import cpr_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [POS_BITS-1:0]  i_mover_x,
    input  logic [POS_BITS-1:0]  i_mover_y,
    input  logic [DIAM_BITS-1:0] i_mover_diameter,
    input  logic [POS_BITS-1:0]  i_fixed_x,
    input  logic [POS_BITS-1:0]  i_fixed_y,
    input  logic [DIAM_BITS-1:0] i_fixed_diameter,
    output logic                 o_strobe,
    output logic [POS_BITS-1:0]  o_resolved_x,
    output logic [POS_BITS-1:0]  o_resolved_y,
    output logic                 o_pushed
);

    localparam int XW = POS_BITS + 2;

    typedef struct packed {
        logic                overlap;
        logic                zero;
        logic                sx;
        logic                sy;
        logic [RAD_BITS-1:0] r;
        logic [POS_BITS-1:0] mx;
        logic [POS_BITS-1:0] my;
        logic [POS_BITS-1:0] fx;
        logic [POS_BITS-1:0] fy;
    } t_side;

    t_front_ctl                 f_ctl;
    logic [RAD_BITS-1:0]        f_r;
    logic [SUM_BITS-1:0]        f_s;
    logic signed [CMP_BITS-1:0] f_cx, f_cy;
    logic [POS_BITS-1:0]        f_mx, f_my, f_fx, f_fy;

    t_axis               w_ax [0:Q_BITS];
    t_axis               w_ay [0:Q_BITS];
    logic [SUM_BITS-1:0] w_s  [0:Q_BITS];

    logic [Q_BITS-1:0] r_v;
    t_side             r_side [0:Q_BITS-1];

    logic                r_strobe, r_pushed;
    logic [POS_BITS-1:0] r_x, r_y;

    assign busy = 1'b0;

    cpr_front #(.POS_BITS(POS_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_mx    (i_mover_x),
        .i_my    (i_mover_y),
        .i_md    (i_mover_diameter),
        .i_fx    (i_fixed_x),
        .i_fy    (i_fixed_y),
        .i_fd    (i_fixed_diameter),
        .o_ctl   (f_ctl),
        .o_r     (f_r),
        .o_s     (f_s),
        .o_cx    (f_cx),
        .o_cy    (f_cy),
        .o_mx    (f_mx),
        .o_my    (f_my),
        .o_fx    (f_fx),
        .o_fy    (f_fy)
    );

    // q = 0: e = s, f = -s
    always_comb begin
        w_s[0]    = f_s;
        w_ax[0].e = $signed({{(CMP_BITS-SUM_BITS){1'b0}}, f_s});
        w_ax[0].f = -$signed({{(CMP_BITS-SUM_BITS){1'b0}}, f_s});
        w_ax[0].c = f_cx;
        w_ax[0].q = '0;
        w_ay[0].e = w_ax[0].e;
        w_ay[0].f = w_ax[0].f;
        w_ay[0].c = f_cy;
        w_ay[0].q = '0;
    end

    for (genvar i = 0; i < Q_BITS; i++) begin : g_search
        cpr_search_step #(.K(Q_BITS - 1 - i)) u_step (
            .i_clk (i_clk),
            .i_s   (w_s[i]),
            .i_ax  (w_ax[i]),
            .i_ay  (w_ay[i]),
            .o_s   (w_s[i+1]),
            .o_ax  (w_ax[i+1]),
            .o_ay  (w_ay[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_v      <= {r_v[Q_BITS-2:0], f_ctl.valid};
            r_strobe <= r_v[Q_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= '{overlap: f_ctl.overlap, zero: f_ctl.zero, sx: f_ctl.sx,
                       sy: f_ctl.sy, r: f_r, mx: f_mx, my: f_my, fx: f_fx, fy: f_fy};
        for (int k = 1; k < Q_BITS; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    function automatic logic [POS_BITS-1:0] place(logic [POS_BITS-1:0] f,
                                                   logic [RAD_BITS-1:0] o, logic neg);
        logic signed [XW-1:0] off;
        logic signed [XW-1:0] sum;
        off = $signed({{(XW-RAD_BITS){1'b0}}, o});
        if (neg) begin
            off = -off;
        end
        sum = $signed({{2{f[POS_BITS-1]}}, f}) + off;
        if (sum[XW-1:POS_BITS-1] == '0 || sum[XW-1:POS_BITS-1] == '1) begin
            return sum[POS_BITS-1:0];
        end else if (sum[XW-1]) begin
            return {1'b1, {(POS_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(POS_BITS-1){1'b1}}};
        end
    endfunction

    t_side               n_sd;
    logic [RAD_BITS-1:0] n_ox, n_oy;

    always_comb begin
        n_sd = r_side[Q_BITS-1];
        n_ox = n_sd.zero ? n_sd.r : w_ax[Q_BITS].q;
        n_oy = n_sd.zero ? '0 : w_ay[Q_BITS].q;
    end

    always_ff @(posedge i_clk) begin
        r_pushed <= n_sd.overlap;
        if (n_sd.overlap) begin
            r_x <= place(n_sd.fx, n_ox, n_sd.sx);
            r_y <= place(n_sd.fy, n_oy, n_sd.sy);
        end else begin
            r_x <= n_sd.mx;
            r_y <= n_sd.my;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_resolved_x = r_x;
    assign o_resolved_y = r_y;
    assign o_pushed     = r_pushed;

endmodule
